>>> rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by mexp_mulmod and modular_exponentiation_32.
package mexp_pkg;

  localparam int BASE_W    = 32;
  localparam int EXP_W     = 32;
  localparam int MOD_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam int MUL_STEPS = BASE_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] a;
    logic [MOD_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] product;
  } mul_rsp_t;

endpackage

>>> rtl/core/mexp_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of a per cycle, MSB first.
// Depends on mexp_pkg; b must be below m, a is any 32-bit word.
module mexp_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mexp_pkg::MOD_W-1:0] modulus,
  input  mexp_pkg::mul_req_t         req,
  output mexp_pkg::mul_rsp_t         rsp
);
  import mexp_pkg::*;

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(MUL_STEPS - 1);

  logic [BASE_W-1:0] a_sh;
  logic [MOD_W-1:0]  b_reg;
  logic [MOD_W-1:0]  acc;
  logic [MOD_W-1:0]  acc_next;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [MOD_W+1:0]  t;
  logic [MOD_W+2:0]  d1;
  logic [MOD_W+2:0]  d2;

  always_comb begin
    t  = {1'b0, acc, 1'b0} + (a_sh[BASE_W-1] ? {2'b00, b_reg} : '0);
    d1 = {1'b0, t} - {3'b000, modulus};
    d2 = {1'b0, t} - {2'b00, modulus, 1'b0};
    if (!d2[MOD_W+2]) begin
      acc_next = d2[MOD_W-1:0];
    end else if (!d1[MOD_W+2]) begin
      acc_next = d1[MOD_W-1:0];
    end else begin
      acc_next = t[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        a_sh  <= req.a;
        b_reg <= req.b;
        acc   <= '0;
      end else if (busy) begin
        acc  <= acc_next;
        a_sh <= {a_sh[BASE_W-2:0], 1'b0};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

>>> rtl/core/modular_exponentiation_32.sv
// Top level of the modular exponentiation block: config registers, sequencer, output word.
// Depends on mexp_pkg and mexp_mulmod.
//
// Each base word returns base ^ exponent mod modulus by right-to-left square and
// multiply. All products go through one bit-serial modular multiplier. A word
// takes one product to reduce the base, one per set bit of e and one squaring per
// bit below the top set bit of e, where e is the exponent cut to WORD_BITS bits.
// An exponent of zero gives 1 and a modulus of zero gives 0, without the multiplier.
// One word is worked at a time; the next base is taken as soon as the result sits in
// the output register, even while that result is still stalled.
module modular_exponentiation_32 #(
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] register_index,
  input  logic [mexp_pkg::EXP_W-1:0]     write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mexp_pkg::BASE_W-1:0]    base,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mexp_pkg::MOD_W-1:0]     power_result
);
  import mexp_pkg::*;

  localparam int EffBits = (WORD_BITS < EXP_W) ? WORD_BITS : EXP_W;
  localparam logic [EXP_W-1:0] WordMask = EXP_W'((64'(1) << EffBits) - 64'(1));

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_BIT  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state;
  logic [EXP_W-1:0]  exponent;
  logic [MOD_W-1:0]  modulus;
  logic [EXP_W-1:0]  e_reg;
  logic [MOD_W-1:0]  acc;
  logic [MOD_W-1:0]  sq;
  logic [EXP_W-1:0]  e_masked;
  logic              e_last;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  assign e_masked = exponent & WordMask;
  assign e_last   = (e_reg[EXP_W-1:1] == '0);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXP_W'(1);
      modulus  <= MOD_W'(1);
    end else if (write_enable) begin
      case (register_index)
        REG_EXPONENT: exponent <= write_data;
        REG_MODULUS:  modulus  <= write_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            e_reg <= e_masked;
            acc   <= MOD_W'(1);
            if (e_masked == '0) begin
              state <= S_DONE;
            end else if (modulus == '0) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              mul_req.start <= 1'b1;
              mul_req.a     <= base & WordMask;
              mul_req.b     <= MOD_W'(1);
              state         <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_rsp.done) begin
            sq    <= mul_rsp.product;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (e_reg[0]) begin
            mul_req.start <= 1'b1;
            mul_req.a     <= BASE_W'(acc);
            mul_req.b     <= sq;
            state         <= S_MUL;
          end else if (e_last) begin
            state <= S_DONE;
          end else begin
            mul_req.start <= 1'b1;
            mul_req.a     <= BASE_W'(sq);
            mul_req.b     <= sq;
            e_reg         <= e_reg >> 1;
            state         <= S_SQR;
          end
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            acc <= mul_rsp.product;
            if (e_last) begin
              state <= S_DONE;
            end else begin
              mul_req.start <= 1'b1;
              mul_req.a     <= BASE_W'(sq);
              mul_req.b     <= sq;
              e_reg         <= e_reg >> 1;
              state         <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mul_rsp.done) begin
            sq    <= mul_rsp.product;
            state <= S_BIT;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            power_result <= acc;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |=> mul_rsp.busy)
    else $error("multiplier did not start");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the finish state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted word left the sequencer idle");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("product finished with no waiting step");

endmodule
